// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never be true
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sab_pkg.sv =====
// ----------------------------------------------------------------------------
// sab_pkg
// Types shared by the suffix array builder modules.
// ----------------------------------------------------------------------------
package sab_pkg;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_CLR,
        ST_CNT_RD,
        ST_CNT_RK,
        ST_CNT_WR,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_SCT_RD,
        ST_SCT_SEC,
        ST_SCT_RK,
        ST_SCT_WR,
        ST_SEC_TAIL,
        ST_SEC_RD,
        ST_SEC_WR,
        ST_REN_RD,
        ST_REN_A,
        ST_REN_R1,
        ST_REN_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

endpackage

// ===== rtl/sab_ram.sv =====
// ----------------------------------------------------------------------------
// sab_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sab_alu.sv =====
// ----------------------------------------------------------------------------
// sab_alu
// Shared add/subtract unit with magnitude compare, used by the count, prefix-sum, scatter and second-key passes.
// ----------------------------------------------------------------------------
module sab_alu #(
    parameter int W = 9
) (
    input  sab_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [W-1:0]     y,
    output logic             gt
);

    always_comb
    begin
        unique case (op)
            sab_pkg::ALU_ADD: y = a + b;
            sab_pkg::ALU_SUB: y = a - b;
            default:          y = a + b;
        endcase
        gt = (a > b);
    end

endmodule

// ===== rtl/suffix_array_builder_top.sv =====
// ----------------------------------------------------------------------------
// suffix_array_builder_top
// Suffix array builder: prefix doubling with counting-sort passes.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis_*): one text byte per transaction, tlast on the
//   final byte. Bytes past MAX_LEN are dropped and flagged on the results.
//   tready is high only while the block collects text.
//   Output stream (m_axis_*): once the final byte is in, the block sorts
//   and then gives the n sorted 1-based suffix start positions, tlast on
//   the last one, tuser = truncated on every one of the run.
//   The sort is sequenced over one shared add/compare unit and
//   single-port-read RAMs; each counting-sort pass clears all RMAX+1
//   buckets, RMAX = max(ALPHABET, MAX_LEN), then counts, sums and
//   scatters. Output: each result is read (ST_OUT_RD), loaded into the
//   output register (ST_OUT_LD) and held in ST_OUT_WAIT; the next result
//   is only fetched once the receiver has taken it, and a stall simply
//   holds the output register until taken.
//   Reset: control state clears, the block waits for a new text.
//   Bucket counts are cleared by a sweep at the start of every pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module suffix_array_builder_top #(
    parameter int MAX_LEN  = 64,
    parameter int ALPHABET = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    // slave side
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // is_last
    // master side
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] suffix_start, [7] zero fill
    output logic       m_axis_tlast,   // final_rank
    output logic       m_axis_tuser    // [0] truncated
);

    localparam int RMAX = (ALPHABET > MAX_LEN) ? ALPHABET : MAX_LEN;
    localparam int RW   = $clog2(RMAX + 1);     // rank / bucket index
    localparam int PW   = $clog2(MAX_LEN + 1);  // position / count
    localparam int AW   = $clog2(MAX_LEN);      // array address

    // control registers
    sab_pkg::state_t state_reg, state_next;
    logic [PW-1:0]   i_reg, i_next;
    logic [RW-1:0]   j_reg, j_next;
    logic [PW-1:0]   len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic [PW-1:0]   k_reg, k_next;
    logic [RW-1:0]   m_reg, m_next;
    logic [PW-1:0]   p_reg, p_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic            cur_reg, cur_next;
    logic            init_reg, init_next;
    logic            oval_reg, oval_next;

    // datapath registers
    logic [PW-1:0]   s_reg, s_next;
    logic [RW-1:0]   r_reg, r_next;
    logic [PW-1:0]   a_reg, a_next;
    logic [RW-1:0]   r1_reg, r1_next;
    logic [RW-1:0]   prev1_reg, prev1_next;
    logic [RW-1:0]   prev2_reg, prev2_next;
    logic [PW-1:0]   acc_reg, acc_next;
    logic [6:0]      ostart_reg, ostart_next;
    logic            olast_reg, olast_next;
    logic            ouser_reg, ouser_next;

    // memory ports
    logic            txt_we;
    logic [AW-1:0]   txt_waddr, txt_raddr;
    logic [7:0]      txt_rdata;
    logic            rk_we, rk_wbank;
    logic [AW-1:0]   rk_waddr, rk_raddr;
    logic [RW-1:0]   rk_wdata, rk0_rdata, rk1_rdata, rk_rdata;
    logic            sec_we;
    logic [AW-1:0]   sec_waddr, sec_raddr;
    logic [PW-1:0]   sec_wdata, sec_rdata;
    logic            sa_we;
    logic [AW-1:0]   sa_waddr, sa_raddr;
    logic [PW-1:0]   sa_wdata, sa_rdata;
    logic            cnt_we;
    logic [RW-1:0]   cnt_waddr, cnt_raddr;
    logic [PW-1:0]   cnt_wdata, cnt_rdata;

    // shared unit
    sab_pkg::alu_op_t alu_op;
    logic [RW-1:0]    alu_a, alu_b, alu_y;
    logic             alu_gt;

    // scratch
    logic [8:0]      sat;
    logic [PW:0]     apk, k2;
    logic            inr;
    logic [RW-1:0]   r2;
    logic [PW-1:0]   pnew;

    sab_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_txt (
        .clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(s_axis_tdata),
        .raddr(txt_raddr), .rdata(txt_rdata)
    );

    // rank banks: one holds current ranks, the other takes renumbered ones
    sab_ram #(.WIDTH(RW), .DEPTH(MAX_LEN)) u_rk0 (
        .clk(clk), .we(rk_we && !rk_wbank), .waddr(rk_waddr), .wdata(rk_wdata),
        .raddr(rk_raddr), .rdata(rk0_rdata)
    );

    sab_ram #(.WIDTH(RW), .DEPTH(MAX_LEN)) u_rk1 (
        .clk(clk), .we(rk_we && rk_wbank), .waddr(rk_waddr), .wdata(rk_wdata),
        .raddr(rk_raddr), .rdata(rk1_rdata)
    );

    sab_ram #(.WIDTH(PW), .DEPTH(MAX_LEN)) u_sec (
        .clk(clk), .we(sec_we), .waddr(sec_waddr), .wdata(sec_wdata),
        .raddr(sec_raddr), .rdata(sec_rdata)
    );

    sab_ram #(.WIDTH(PW), .DEPTH(MAX_LEN)) u_sa (
        .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata),
        .raddr(sa_raddr), .rdata(sa_rdata)
    );

    sab_ram #(.WIDTH(PW), .DEPTH(RMAX + 1)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    sab_alu #(.W(RW)) u_alu (
        .op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y), .gt(alu_gt)
    );

    assign rk_rdata = cur_reg ? rk1_rdata : rk0_rdata;

    assign s_axis_tready = (state_reg == sab_pkg::ST_LOAD);
    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = {1'b0, ostart_reg};
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = ouser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sab_pkg::ST_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
            m_reg     <= '0;
            p_reg     <= '0;
            pos_reg   <= '0;
            cur_reg   <= 1'b0;
            init_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            p_reg     <= p_next;
            pos_reg   <= pos_next;
            cur_reg   <= cur_next;
            init_reg  <= init_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        r_reg      <= r_next;
        a_reg      <= a_next;
        r1_reg     <= r1_next;
        prev1_reg  <= prev1_next;
        prev2_reg  <= prev2_next;
        acc_reg    <= acc_next;
        ostart_reg <= ostart_next;
        olast_reg  <= olast_next;
        ouser_reg  <= ouser_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        k_next      = k_reg;
        m_next      = m_reg;
        p_next      = p_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        init_next   = init_reg;
        oval_next   = oval_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        a_next      = a_reg;
        r1_next     = r1_reg;
        prev1_next  = prev1_reg;
        prev2_next  = prev2_reg;
        acc_next    = acc_reg;
        ostart_next = ostart_reg;
        olast_next  = olast_reg;
        ouser_next  = ouser_reg;

        txt_we    = 1'b0;
        txt_waddr = AW'(len_reg);
        txt_raddr = AW'(i_reg - PW'(1));
        rk_we     = 1'b0;
        rk_wbank  = cur_reg;
        rk_waddr  = '0;
        rk_wdata  = '0;
        rk_raddr  = '0;
        sec_we    = 1'b0;
        sec_waddr = AW'(pos_reg);
        sec_wdata = '0;
        sec_raddr = AW'(i_reg - PW'(1));
        sa_we     = 1'b0;
        sa_waddr  = '0;
        sa_wdata  = s_reg;
        sa_raddr  = AW'(i_reg - PW'(1));
        cnt_we    = 1'b0;
        cnt_waddr = j_reg;
        cnt_wdata = '0;
        cnt_raddr = j_reg;
        alu_op    = sab_pkg::ALU_ADD;
        alu_a     = '0;
        alu_b     = '0;

        sat  = (9'(txt_rdata) >= 9'(ALPHABET)) ? 9'(ALPHABET - 1) : 9'(txt_rdata);
        apk  = (PW+1)'(a_reg) + (PW+1)'(k_reg);
        k2   = {k_reg, 1'b0};
        inr  = (apk <= (PW+1)'(len_reg));
        r2   = inr ? rk_rdata : '0;
        pnew = p_reg + PW'(1);
        if (i_reg == PW'(1))
        begin
            pnew = PW'(1);
        end
        else if (r1_reg == prev1_reg && r2 == prev2_reg)
        begin
            pnew = p_reg;
        end

        unique case (state_reg)
            sab_pkg::ST_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    if (len_reg < PW'(MAX_LEN))
                    begin
                        txt_we   = 1'b1;
                        len_next = len_reg + PW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        i_next     = PW'(1);
                        init_next  = 1'b1;
                        state_next = sab_pkg::ST_INIT_RD;
                    end
                end
            end

            // initial ranks from bytes, identity second-key order
            sab_pkg::ST_INIT_RD:
            begin
                state_next = sab_pkg::ST_INIT_WR;
            end

            sab_pkg::ST_INIT_WR:
            begin
                rk_we     = 1'b1;
                rk_waddr  = AW'(i_reg - PW'(1));
                rk_wdata  = RW'(sat) + RW'(1);
                sec_we    = 1'b1;
                sec_waddr = AW'(i_reg - PW'(1));
                sec_wdata = i_reg;
                if (i_reg == len_reg)
                begin
                    m_next     = RW'(ALPHABET);
                    j_next     = '0;
                    state_next = sab_pkg::ST_CLR;
                end
                else
                begin
                    i_next     = i_reg + PW'(1);
                    state_next = sab_pkg::ST_INIT_RD;
                end
            end

            sab_pkg::ST_CLR:
            begin
                cnt_we = 1'b1;
                if (j_reg == RW'(RMAX))
                begin
                    i_next     = PW'(1);
                    state_next = sab_pkg::ST_CNT_RD;
                end
                else
                begin
                    j_next = j_reg + RW'(1);
                end
            end

            // histogram of current ranks
            sab_pkg::ST_CNT_RD:
            begin
                rk_raddr   = AW'(i_reg - PW'(1));
                state_next = sab_pkg::ST_CNT_RK;
            end

            sab_pkg::ST_CNT_RK:
            begin
                r_next     = rk_rdata;
                cnt_raddr  = rk_rdata;
                state_next = sab_pkg::ST_CNT_WR;
            end

            sab_pkg::ST_CNT_WR:
            begin
                alu_a     = RW'(cnt_rdata);
                alu_b     = RW'(1);
                cnt_we    = 1'b1;
                cnt_waddr = r_reg;
                cnt_wdata = PW'(alu_y);
                if (i_reg == len_reg)
                begin
                    j_next     = RW'(1);
                    acc_next   = '0;
                    state_next = sab_pkg::ST_PFX_RD;
                end
                else
                begin
                    i_next     = i_reg + PW'(1);
                    state_next = sab_pkg::ST_CNT_RD;
                end
            end

            // running sum over buckets 1..m
            sab_pkg::ST_PFX_RD:
            begin
                state_next = sab_pkg::ST_PFX_WR;
            end

            sab_pkg::ST_PFX_WR:
            begin
                alu_a     = RW'(acc_reg);
                alu_b     = RW'(cnt_rdata);
                cnt_we    = 1'b1;
                cnt_wdata = PW'(alu_y);
                acc_next  = PW'(alu_y);
                if (j_reg == m_reg)
                begin
                    i_next     = len_reg;
                    state_next = sab_pkg::ST_SCT_RD;
                end
                else
                begin
                    j_next     = j_reg + RW'(1);
                    state_next = sab_pkg::ST_PFX_RD;
                end
            end

            // scatter in reverse second-key order
            sab_pkg::ST_SCT_RD:
            begin
                state_next = sab_pkg::ST_SCT_SEC;
            end

            sab_pkg::ST_SCT_SEC:
            begin
                s_next     = sec_rdata;
                rk_raddr   = AW'(sec_rdata - PW'(1));
                state_next = sab_pkg::ST_SCT_RK;
            end

            sab_pkg::ST_SCT_RK:
            begin
                r_next     = rk_rdata;
                cnt_raddr  = rk_rdata;
                state_next = sab_pkg::ST_SCT_WR;
            end

            sab_pkg::ST_SCT_WR:
            begin
                alu_op    = sab_pkg::ALU_SUB;
                alu_a     = RW'(cnt_rdata);
                alu_b     = RW'(1);
                sa_we     = 1'b1;
                sa_waddr  = AW'(cnt_rdata - PW'(1));
                cnt_we    = 1'b1;
                cnt_waddr = r_reg;
                cnt_wdata = PW'(alu_y);
                if (i_reg == PW'(1))
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        k_next     = PW'(1);
                        pos_next   = '0;
                        i_next     = len_reg;
                        state_next = sab_pkg::ST_SEC_TAIL;
                    end
                    else
                    begin
                        i_next     = PW'(1);
                        state_next = sab_pkg::ST_REN_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg - PW'(1);
                    state_next = sab_pkg::ST_SCT_RD;
                end
            end

            // second-key order: tail positions first, then shifted order
            sab_pkg::ST_SEC_TAIL:
            begin
                sec_we    = 1'b1;
                sec_wdata = i_reg;
                pos_next  = pos_reg + PW'(1);
                if (i_reg == len_reg)
                begin
                    i_next     = PW'(1);
                    state_next = sab_pkg::ST_SEC_RD;
                end
                else
                begin
                    i_next = i_reg + PW'(1);
                end
            end

            sab_pkg::ST_SEC_RD:
            begin
                state_next = sab_pkg::ST_SEC_WR;
            end

            sab_pkg::ST_SEC_WR:
            begin
                alu_op    = sab_pkg::ALU_SUB;
                alu_a     = RW'(sa_rdata);
                alu_b     = RW'(k_reg);
                sec_wdata = PW'(alu_y);
                if (alu_gt)
                begin
                    sec_we   = 1'b1;
                    pos_next = pos_reg + PW'(1);
                end
                if (i_reg == len_reg)
                begin
                    j_next     = '0;
                    state_next = sab_pkg::ST_CLR;
                end
                else
                begin
                    i_next     = i_reg + PW'(1);
                    state_next = sab_pkg::ST_SEC_RD;
                end
            end

            // dense renumbering by (rank, rank at +k)
            sab_pkg::ST_REN_RD:
            begin
                state_next = sab_pkg::ST_REN_A;
            end

            sab_pkg::ST_REN_A:
            begin
                a_next     = sa_rdata;
                rk_raddr   = AW'(sa_rdata - PW'(1));
                state_next = sab_pkg::ST_REN_R1;
            end

            sab_pkg::ST_REN_R1:
            begin
                r1_next    = rk_rdata;
                rk_raddr   = AW'(apk - (PW+1)'(1));
                state_next = sab_pkg::ST_REN_WR;
            end

            sab_pkg::ST_REN_WR:
            begin
                rk_we      = 1'b1;
                rk_wbank   = !cur_reg;
                rk_waddr   = AW'(a_reg - PW'(1));
                rk_wdata   = RW'(pnew);
                prev1_next = r1_reg;
                prev2_next = r2;
                p_next     = pnew;
                if (i_reg == len_reg)
                begin
                    cur_next = !cur_reg;
                    if (pnew == len_reg || k2 > (PW+1)'(len_reg))
                    begin
                        i_next     = PW'(1);
                        state_next = sab_pkg::ST_OUT_RD;
                    end
                    else
                    begin
                        k_next     = PW'(k2);
                        m_next     = RW'(pnew);
                        pos_next   = '0;
                        i_next     = PW'((PW+1)'(len_reg) - k2 + (PW+1)'(1));
                        state_next = sab_pkg::ST_SEC_TAIL;
                    end
                end
                else
                begin
                    i_next     = i_reg + PW'(1);
                    state_next = sab_pkg::ST_REN_RD;
                end
            end

            // result delivery
            sab_pkg::ST_OUT_RD:
            begin
                state_next = sab_pkg::ST_OUT_LD;
            end

            sab_pkg::ST_OUT_LD:
            begin
                ostart_next = 7'(sa_rdata);
                olast_next  = (i_reg == len_reg);
                ouser_next  = ovf_reg;
                oval_next   = 1'b1;
                state_next  = sab_pkg::ST_OUT_WAIT;
            end

            sab_pkg::ST_OUT_WAIT:
            begin
                if (m_axis_tready)
                begin
                    oval_next = 1'b0;
                    if (olast_reg)
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = sab_pkg::ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + PW'(1);
                        state_next = sab_pkg::ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = sab_pkg::ST_LOAD;
            end
        endcase
    end

    // assertions
    `ASSERT_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid,
        "input accepted while a result is pending")
    `ASSERT_NEVER(a_len_range, len_reg > PW'(MAX_LEN), "text length beyond store")
    `ASSERT_NEXT(a_back_to_load, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        s_axis_tready, "not ready for new text after final result")
    `ASSERT_IMPL(a_valid_state, m_axis_tvalid,
        state_reg == sab_pkg::ST_OUT_WAIT, "result shown outside delivery")

endmodule
